FILE: design/pstd_pkg.sv
// Shared constants, codes and types of the publish/subscribe dispatch table.
package pstd_pkg;

   localparam int TOPICS          = 256;
   localparam int SLOTS_PER_TOPIC = 8;
   localparam int QUEUE_DEPTH     = 4;

   localparam int TOPIC_W     = $clog2(TOPICS);
   localparam int SLOT_W      = $clog2(SLOTS_PER_TOPIC);
   localparam int SLOT_ADDR_W = TOPIC_W + SLOT_W;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 3;

   typedef enum logic [1:0] {
      KIND_SUBSCRIBE   = 2'd0,
      KIND_UNSUBSCRIBE = 2'd1,
      KIND_PUBLISH     = 2'd2,
      KIND_DISPATCH    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_REJECTED    = 2'd1,
      STATUS_QUEUE_FULL  = 2'd2,
      STATUS_QUEUE_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROW,
      ST_LOAD,
      ST_ISSUE,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [7:0] group;
      logic [7:0] process;
      logic [7:0] handler;
   } slot_entry_type;

   typedef struct packed {
      logic [31:0] data;
      logic [7:0]  group;
      logic [7:0]  topic;
   } queue_entry_type;

   localparam int SLOT_ENTRY_W = $bits(slot_entry_type);

endpackage

FILE: design/pstd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pstd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/pubsub_topic_dispatch_table_top.sv
// Top level of the publish/subscribe dispatch table.
//
// Requests enter on the req_ channel: req_tuser carries the kind (subscribe,
// unsubscribe, publish, dispatch) and req_tdata the topic, group, process,
// handler tag and payload. Results leave on the rsp_ channel, one or more
// per request, and rsp_tlast marks the final result of a request.
// A single sequencer walks the topic's slots one at a time with one shared
// compare unit. Each slot gets a slot memory read and then a check.
// Subscribe and unsubscribe take a row read, eight slot checks and a result,
// and accept the next request in the cycle that result appears; a dispatch
// with a queued message takes at most as long. Publish and a dispatch on an
// empty queue go from acceptance straight to the result state, which
// registers their result. A broadcast dispatch gives one result per
// valid slot as it finds them. req_tready is high only between requests, so
// one request is in flight at a time.
// After reset the valid-bit memory is swept clear, one topic row per cycle,
// with req_tready low until all 256 rows are clear.
// A result sits in an output register until taken; when the receiver stalls
// the sequencer waits at the next result and holds its position.
module pubsub_topic_dispatch_table_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // topic_id[7:0], group_num[15:8], process_id[23:16], handler_tag[31:24],
   // payload[63:32]
   input  logic [pstd_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [pstd_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // target_handler[7:0], target_process[15:8], out_topic[23:16],
   // out_data[55:24]
   output logic [pstd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0], delivered[2]
   output logic [pstd_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                          rsp_tlast
);

   import pstd_pkg::*;

   state_type                  state_ff, state_in;
   kind_type                   kind_ff, kind_in;
   status_type                 status_ff, status_in;
   logic [7:0]                 topic_ff, topic_in;
   logic [7:0]                 group_ff, group_in;
   logic [7:0]                 proc_ff, proc_in;
   logic [7:0]                 handler_ff, handler_in;
   logic [31:0]                data_ff, data_in;
   logic [SLOTS_PER_TOPIC-1:0] row_ff, row_in;
   logic [SLOT_W-1:0]          j_ff, j_in;
   logic [SLOT_W-1:0]          hit_j_ff, hit_j_in;
   logic                       dup_ff, dup_in;
   logic                       found_ff, found_in;
   logic [TOPIC_W-1:0]         clr_cnt_ff, clr_cnt_in;

   queue_entry_type            q_entry_ff [QUEUE_DEPTH];
   queue_entry_type            q_entry_in;
   logic                       q_push;
   logic [QPTR_W-1:0]          q_head_ff, q_head_in;
   logic [QPTR_W-1:0]          q_tail_ff, q_tail_in;
   logic [QCNT_W-1:0]          q_count_ff, q_count_in;

   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]      rsp_tdata_ff, rsp_tdata_in;
   logic [RSP_USER_W-1:0]      rsp_tuser_ff, rsp_tuser_in;
   logic                       rsp_tlast_ff, rsp_tlast_in;

   logic                       row_wr_en;
   logic [TOPIC_W-1:0]         row_wr_addr;
   logic [SLOTS_PER_TOPIC-1:0] row_wr_data;
   logic [SLOTS_PER_TOPIC-1:0] row_rd_data;
   logic                       slot_wr_en;
   slot_entry_type             slot_wr_data;
   slot_entry_type             slot_rd;
   logic [SLOT_ENTRY_W-1:0]    slot_rd_data;
   logic [TOPIC_W-1:0]         topic_idx;

   logic                       req_accept;
   logic                       out_free;
   logic                       q_full;
   logic                       q_empty;
   logic                       j_last;
   logic                       slot_match;
   logic                       deliver_hit;
   logic                       deliver_last;
   logic [SLOTS_PER_TOPIC-1:0] later_rows;
   logic [SLOT_W-1:0]          free_j;
   logic                       free_any;
   logic                       sub_ok;
   logic [SLOTS_PER_TOPIC-1:0] one_bit;

   // Topic index into the tables; the reported topic stays the raw value.
   assign topic_idx  = topic_ff[TOPIC_W-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign q_full     = (q_count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_empty    = (q_count_ff == '0);
   assign j_last     = (j_ff == SLOT_W'(SLOTS_PER_TOPIC - 1));
   assign one_bit    = {{(SLOTS_PER_TOPIC-1){1'b0}}, 1'b1};

   assign slot_rd = slot_entry_type'(slot_rd_data);

   // Shared compare unit, applied to one slot per check cycle.
   assign slot_match = row_ff[j_ff] && (slot_rd.process == proc_ff) &&
                       (slot_rd.group == group_ff);
   assign deliver_hit = (kind_ff == KIND_DISPATCH) && row_ff[j_ff] &&
                        ((group_ff == 8'd0) || (slot_rd.group == group_ff));
   assign later_rows   = (row_ff >> j_ff) >> 1;
   assign deliver_last = (group_ff != 8'd0) || (later_rows == '0);

   always_comb begin : free_search
      free_j = '0;
      for (int i = SLOTS_PER_TOPIC - 1; i >= 0; i--) begin
         if (!row_ff[i]) begin
            free_j = SLOT_W'(i);
         end
      end
   end

   assign free_any = !(&row_ff);
   assign sub_ok   = !dup_ff && free_any;

   pstd_ram #(
      .WIDTH (SLOTS_PER_TOPIC),
      .DEPTH (TOPICS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (row_wr_data),
      .rd_addr (topic_idx),
      .rd_data (row_rd_data)
   );

   pstd_ram #(
      .WIDTH (SLOT_ENTRY_W),
      .DEPTH (TOPICS * SLOTS_PER_TOPIC)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr ({topic_idx, free_j}),
      .wr_data (slot_wr_data),
      .rd_addr ({topic_idx, j_ff}),
      .rd_data (slot_rd_data)
   );

   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == TOPIC_W'(TOPICS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (kind_type'(req_tuser))
                  KIND_SUBSCRIBE:   state_in = ST_ROW;
                  KIND_UNSUBSCRIBE: state_in = ST_ROW;
                  KIND_DISPATCH:    state_in = q_empty ? ST_DONE : ST_ROW;
                  default:          state_in = ST_DONE;
               endcase
            end
         end
         ST_ROW:   state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_ISSUE;
         ST_ISSUE: state_in = ST_CHECK;
         ST_CHECK: begin
            if (deliver_hit && !out_free) begin
               state_in = ST_CHECK;
            end else if (deliver_hit && deliver_last) begin
               state_in = ST_IDLE;
            end else if (j_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_ISSUE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin : datapath
      kind_in       = kind_ff;
      status_in     = status_ff;
      topic_in      = topic_ff;
      group_in      = group_ff;
      proc_in       = proc_ff;
      handler_in    = handler_ff;
      data_in       = data_ff;
      row_in        = row_ff;
      j_in          = j_ff;
      hit_j_in      = hit_j_ff;
      dup_in        = dup_ff;
      found_in      = found_ff;
      clr_cnt_in    = clr_cnt_ff;
      q_push        = 1'b0;
      q_entry_in    = '{data: req_tdata[63:32], group: req_tdata[15:8],
                        topic: req_tdata[7:0]};
      q_head_in     = q_head_ff;
      q_tail_in     = q_tail_ff;
      q_count_in    = q_count_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      row_wr_en     = 1'b0;
      row_wr_addr   = topic_idx;
      row_wr_data   = row_ff;
      slot_wr_en    = 1'b0;
      slot_wr_data  = '{group: group_ff, process: proc_ff, handler: handler_ff};

      case (state_ff)
         ST_CLEAR: begin
            row_wr_en   = 1'b1;
            row_wr_addr = clr_cnt_ff;
            row_wr_data = '0;
            clr_cnt_in  = clr_cnt_ff + TOPIC_W'(1);
         end
         ST_IDLE: begin
            if (req_accept) begin
               kind_in    = kind_type'(req_tuser);
               topic_in   = req_tdata[7:0];
               group_in   = req_tdata[15:8];
               proc_in    = req_tdata[23:16];
               handler_in = req_tdata[31:24];
               data_in    = req_tdata[63:32];
               dup_in     = 1'b0;
               found_in   = 1'b0;
               status_in  = STATUS_OK;
               if (kind_type'(req_tuser) == KIND_PUBLISH) begin
                  if (q_full) begin
                     status_in = STATUS_QUEUE_FULL;
                  end else begin
                     q_push     = 1'b1;
                     q_tail_in  = (q_tail_ff == QPTR_W'(QUEUE_DEPTH - 1)) ?
                                  '0 : q_tail_ff + QPTR_W'(1);
                     q_count_in = q_count_ff + QCNT_W'(1);
                  end
               end else if (kind_type'(req_tuser) == KIND_DISPATCH) begin
                  if (q_empty) begin
                     status_in = STATUS_QUEUE_EMPTY;
                  end else begin
                     topic_in   = q_entry_ff[q_head_ff].topic;
                     group_in   = q_entry_ff[q_head_ff].group;
                     data_in    = q_entry_ff[q_head_ff].data;
                     q_head_in  = (q_head_ff == QPTR_W'(QUEUE_DEPTH - 1)) ?
                                  '0 : q_head_ff + QPTR_W'(1);
                     q_count_in = q_count_ff - QCNT_W'(1);
                  end
               end
            end
         end
         ST_LOAD: begin
            row_in = row_rd_data;
            j_in   = '0;
         end
         ST_CHECK: begin
            if (slot_match && (kind_ff == KIND_SUBSCRIBE)) begin
               dup_in = 1'b1;
            end
            if (slot_match && (kind_ff == KIND_UNSUBSCRIBE) && !found_ff) begin
               found_in = 1'b1;
               hit_j_in = j_ff;
            end
            if (deliver_hit && out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {data_ff, topic_ff, slot_rd.process, slot_rd.handler};
               rsp_tuser_in  = {1'b1, STATUS_OK};
               rsp_tlast_in  = deliver_last;
            end
            if (!(deliver_hit && !out_free) && !j_last) begin
               j_in = j_ff + SLOT_W'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tlast_in  = 1'b1;
               rsp_tdata_in  = '0;
               case (kind_ff)
                  KIND_SUBSCRIBE: begin
                     rsp_tuser_in = {1'b0, sub_ok ? STATUS_OK : STATUS_REJECTED};
                     if (sub_ok) begin
                        slot_wr_en  = 1'b1;
                        row_wr_en   = 1'b1;
                        row_wr_data = row_ff | (one_bit << free_j);
                     end
                  end
                  KIND_UNSUBSCRIBE: begin
                     rsp_tuser_in = {1'b0, STATUS_OK};
                     if (found_ff) begin
                        row_wr_en   = 1'b1;
                        row_wr_data = row_ff & ~(one_bit << hit_j_ff);
                     end
                  end
                  KIND_DISPATCH: begin
                     rsp_tuser_in = {1'b0, status_ff};
                     // A message that reached no subscriber still reports itself.
                     if (status_ff == STATUS_OK) begin
                        rsp_tdata_in = {data_ff, topic_ff, 16'd0};
                     end
                  end
                  default: begin
                     rsp_tuser_in = {1'b0, status_ff};
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         q_head_ff     <= '0;
         q_tail_ff     <= '0;
         q_count_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         q_head_ff     <= q_head_in;
         q_tail_ff     <= q_tail_in;
         q_count_ff    <= q_count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      status_ff    <= status_in;
      topic_ff     <= topic_in;
      group_ff     <= group_in;
      proc_ff      <= proc_in;
      handler_ff   <= handler_in;
      data_ff      <= data_in;
      row_ff       <= row_in;
      j_ff         <= j_in;
      hit_j_ff     <= hit_j_in;
      dup_ff       <= dup_in;
      found_ff     <= found_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
      if (q_push) begin
         q_entry_ff[q_tail_ff] <= q_entry_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

FILE: design/pstd_checker.sv
// Port-level checker for the dispatch table, bound to the top level.
module pstd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [pstd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [pstd_pkg::RSP_USER_W-1:0] rsp_tuser,
   input logic                          rsp_tlast
);

   import pstd_pkg::*;

   // The valid-bit sweep keeps requests out right after reset.
   a_reset_blocks_req: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request channel ready right after reset");

   // Only one request is in flight at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in flight");

   // Only deliveries can be followed by more results of the same request.
   a_plain_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[RSP_USER_W-1] |-> rsp_tlast)
      else $error("non-delivery result not marked last");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind pubsub_topic_dispatch_table_top pstd_checker u_pstd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
